@@ rtl/mfr_pkg.sv @@
// Package for the MAVLink frame receiver: constants, CRC step and CRC extra table.
`default_nettype none

package mfr_pkg;

    // Size of the frame byte window; the position counter is sized from it
    localparam int BUFFER_BYTES = 512;
    localparam int COUNT_W      = $clog2(BUFFER_BYTES);

    // Configuration register indexes
    localparam int CFG_INDEX_W            = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_V2_MAGIC = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_V1_MAGIC = CFG_INDEX_W'(1);

    // Reset values of the start bytes
    localparam logic [7:0] V2_MAGIC_RESET = 8'd253;
    localparam logic [7:0] V1_MAGIC_RESET = 8'd254;

    // Frame layout
    localparam int POS_LENGTH   = 1;
    localparam int V1_POS_ID    = 5;
    localparam int V2_POS_ID_LO = 7;
    localparam int V2_POS_ID_HI = 8;
    localparam int V1_OVERHEAD  = 8;
    localparam int V2_OVERHEAD  = 12;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // One byte of CRC-16/MCRF4XX (reflected 0x1021)
    function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] crc);
        logic [7:0]  t;
        logic [15:0] tw;
        t  = b ^ crc[7:0];
        t  = t ^ (t << 4);
        tw = {8'd0, t};
        return (crc >> 8) ^ {t, 8'd0} ^ (tw << 3) ^ (tw >> 4);
    endfunction

    // Per-message CRC extra byte; zero marks an id not in the table
    function automatic logic [7:0] crc_extra(input logic [15:0] id);
        logic [7:0] extra;
        case (id)
            16'd0:   extra = 8'd50;
            16'd1:   extra = 8'd124;
            16'd20:  extra = 8'd214;
            16'd21:  extra = 8'd159;
            16'd22:  extra = 8'd220;
            16'd24:  extra = 8'd24;
            16'd30:  extra = 8'd39;
            16'd33:  extra = 8'd104;
            16'd42:  extra = 8'd141;
            16'd44:  extra = 8'd221;
            16'd45:  extra = 8'd132;
            16'd47:  extra = 8'd221;
            16'd66:  extra = 8'd148;
            16'd74:  extra = 8'd20;
            16'd76:  extra = 8'd152;
            16'd147: extra = 8'd154;
            16'd253: extra = 8'd83;
            default: extra = 8'd0;
        endcase
        return extra;
    endfunction

    // Ground-station id list; it is consulted only for v2 ids that have no CRC extra byte
    function automatic logic is_gcs_id(input logic [15:0] id);
        return (id == 16'd20) || (id == 16'd21) || (id == 16'd45) ||
               (id == 16'd66) || (id == 16'd76);
    endfunction

endpackage

`default_nettype wire

@@ rtl/mfr_if.sv @@
// Channel interfaces of the MAVLink frame receiver: byte input, frame result, config write.
`default_nettype none

interface mfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfr_result_if;
    logic        valid;
    logic        ready;
    logic        frame_accepted;
    logic        is_version_two;
    logic [15:0] message_id;
    logic [7:0]  payload_length;

    modport source (output valid, output frame_accepted, output is_version_two,
                    output message_id, output payload_length, input ready);
    modport sink   (input valid, input frame_accepted, input is_version_two,
                    input message_id, input payload_length, output ready);
endinterface

interface mfr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mfr_pkg::CFG_INDEX_W-1:0] index;
    logic [7:0]                  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/mavlink_frame_receiver.sv @@
// Top level of the MAVLink v1/v2 frame receiver with CRC-16/MCRF4XX check.
//
// Link bytes arrive on byte_in, one per transfer, and a frame result leaves on result_out
// when the last checksum byte of a frame has been seen. The block takes one byte per clock
// cycle while not stalled; a byte is captured in an input register and then worked on,
// where the one-byte CRC update of the running CRC register and the position compare are
// done, so result_out.valid rises once the frame's last byte has passed the input register
// and the result register, or later while an earlier result still waits. byte_in stalls
// only while a result waits on result_out and a captured byte still needs to be worked on.
// A frame starts with the v2 or v1 start byte from the configuration registers (v2 wins if
// they match); a frame that starts with any other byte drops that byte and the next one
// and gives no result. The configuration channel is always ready; the user must write it
// while the block is idle; the block does not enforce it. No clearing pass follows reset.
`default_nettype none

module mavlink_frame_receiver (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mfr_byte_if.sink    byte_in,
    mfr_result_if.source result_out,
    mfr_cfg_if.sink     cfg
);
    import mfr_pkg::*;

    // Configuration registers
    logic [7:0] v2_magic_reg;
    logic [7:0] v1_magic_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Frame state
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic               version_reg, version_next;
    logic               bad_reg,     bad_next;
    logic [7:0]         length_reg,  length_next;
    logic [15:0]        id_reg,      id_next;
    logic [15:0]        crc_reg,     crc_next;
    logic [7:0]         csum_lo_reg, csum_lo_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic        out_ok_reg,    out_ok_next;
    logic        out_v2_reg,    out_v2_next;
    logic [15:0] out_id_reg,    out_id_next;
    logic [7:0]  out_len_reg,   out_len_next;

    logic               advance;
    logic [COUNT_W-1:0] total;
    logic [15:0]        id_upd;
    logic [7:0]         extra;
    logic [15:0]        final_crc;
    logic               frame_ok;

    // Work on the captured byte whenever the result register can take a result
    assign advance       = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign byte_in.ready = !in_valid_reg || advance;
    assign cfg.ready     = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_magic_reg <= V2_MAGIC_RESET;
            v1_magic_reg <= V1_MAGIC_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_V2_MAGIC)
                v2_magic_reg <= cfg.data;
            else if (cfg.index == CFG_V1_MAGIC)
                v1_magic_reg <= cfg.data;
        end
    end

    // Capture one byte per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_in.ready)
            in_valid_reg <= byte_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
            in_byte_reg <= byte_in.rx_byte;
    end

    // Frame length in bytes; at most 267, which the counter always holds
    assign total = COUNT_W'(length_reg) +
                   (version_reg ? COUNT_W'(V2_OVERHEAD) : COUNT_W'(V1_OVERHEAD));

    // Pick up the message id bytes at their header positions
    always_comb
    begin
        id_upd = id_reg;
        if (version_reg)
        begin
            if (count_reg == COUNT_W'(V2_POS_ID_LO))
                id_upd[7:0] = in_byte_reg;
            if (count_reg == COUNT_W'(V2_POS_ID_HI))
                id_upd[15:8] = in_byte_reg;
        end
        else if (count_reg == COUNT_W'(V1_POS_ID))
        begin
            id_upd = {8'd0, in_byte_reg};
        end
    end

    // Fold in the CRC extra and check against the trailing checksum
    assign extra     = crc_extra(id_upd);
    assign final_crc = crc_step(extra, crc_reg);
    assign frame_ok  = (version_reg && extra == 8'd0) ? is_gcs_id(id_upd)
                                                      : (final_crc == {in_byte_reg, csum_lo_reg});

    // Advance the frame state by one byte
    always_comb
    begin
        count_next     = count_reg;
        version_next   = version_reg;
        bad_next       = bad_reg;
        length_next    = length_reg;
        id_next        = id_reg;
        crc_next       = crc_reg;
        csum_lo_next   = csum_lo_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        out_ok_next    = out_ok_reg;
        out_v2_next    = out_v2_reg;
        out_id_next    = out_id_reg;
        out_len_next   = out_len_reg;

        if (advance)
        begin
            if (count_reg == '0)
            begin
                // Start byte: latch the framing
                crc_next     = CRC_INIT;
                id_next      = 16'd0;
                csum_lo_next = 8'd0;
                if (in_byte_reg == v2_magic_reg)
                begin
                    version_next = 1'b1;
                    bad_next     = 1'b0;
                end
                else if (in_byte_reg == v1_magic_reg)
                begin
                    version_next = 1'b0;
                    bad_next     = 1'b0;
                end
                else
                begin
                    version_next = 1'b0;
                    bad_next     = 1'b1;
                end
                count_next = COUNT_W'(1);
            end
            else if (bad_reg)
            begin
                // Drop the byte after a bad start byte
                bad_next   = 1'b0;
                count_next = '0;
            end
            else if (count_reg == COUNT_W'(POS_LENGTH))
            begin
                length_next = in_byte_reg;
                crc_next    = crc_step(in_byte_reg, crc_reg);
                count_next  = COUNT_W'(2);
            end
            else
            begin
                id_next = id_upd;
                if (count_reg <= total - COUNT_W'(3))
                begin
                    crc_next   = crc_step(in_byte_reg, crc_reg);
                    count_next = count_reg + COUNT_W'(1);
                end
                else if (count_reg == total - COUNT_W'(2))
                begin
                    csum_lo_next = in_byte_reg;
                    count_next   = count_reg + COUNT_W'(1);
                end
                else
                begin
                    // Last checksum byte: hand out the result
                    out_valid_next = 1'b1;
                    out_ok_next    = frame_ok;
                    out_v2_next    = version_reg;
                    out_id_next    = id_upd;
                    out_len_next   = length_reg;
                    count_next     = '0;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            version_reg   <= 1'b0;
            bad_reg       <= 1'b0;
            length_reg    <= 8'd0;
            id_reg        <= 16'd0;
            crc_reg       <= CRC_INIT;
            csum_lo_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            version_reg   <= version_next;
            bad_reg       <= bad_next;
            length_reg    <= length_next;
            id_reg        <= id_next;
            crc_reg       <= crc_next;
            csum_lo_reg   <= csum_lo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        out_ok_reg  <= out_ok_next;
        out_v2_reg  <= out_v2_next;
        out_id_reg  <= out_id_next;
        out_len_reg <= out_len_next;
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.frame_accepted = out_ok_reg;
    assign result_out.is_version_two = out_v2_reg;
    assign result_out.message_id     = out_id_reg;
    assign result_out.payload_length = out_len_reg;

endmodule

`default_nettype wire

@@ rtl/mfr_checker.sv @@
// Port checker for the MAVLink frame receiver and its bind to the top level.
`default_nettype none

module mfr_checker (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mfr_byte_if.sink     byte_in,
    mfr_result_if.source result_out,
    mfr_cfg_if.sink      cfg
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && !result_out.ready |=>
            result_out.valid && $stable(result_out.frame_accepted) &&
            $stable(result_out.is_version_two) && $stable(result_out.message_id) &&
            $stable(result_out.payload_length))
        else $error("result changed while stalled");

    // Stall byte input only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_in.ready |-> result_out.valid && !result_out.ready)
        else $error("byte input stalled without a waiting result");

    // A fresh result is raised after the byte transfer that completes a frame has passed the input register
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_out.valid) |-> $past(byte_in.valid && byte_in.ready, 2))
        else $error("result without the byte that completes the frame");

    // Frames are several bytes long, so results never transfer in consecutive cycles
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.ready |=> !(result_out.valid && result_out.ready))
        else $error("two results in consecutive cycles");

    // A version one id is a single byte
    a_v1_id_width: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && !result_out.is_version_two |-> result_out.message_id[15:8] == 8'd0)
        else $error("version one result with a wide message id");

endmodule

bind mavlink_frame_receiver mfr_checker u_mfr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_in    (byte_in),
    .result_out (result_out),
    .cfg        (cfg)
);

`default_nettype wire

@@ dv/mfr_frame_checker.sv @@
// Frame result checker for the MAVLink receiver bench, with the CRC helpers it shares with the top.
`timescale 1ns / 1ps

package mfr_tb_ref;

    localparam logic [7:0]  START_V2_AT_RESET = 8'd253;
    localparam logic [7:0]  START_V1_AT_RESET = 8'd254;
    localparam logic [15:0] CRC_SEED          = 16'hFFFF;

    typedef struct packed {
        logic        accepted;
        logic        v2;
        logic [15:0] id;
        logic [7:0]  len;
    } frame_result_t;

    // One byte of CRC-16/MCRF4XX
    function automatic logic [15:0] mcrf4xx_update(input logic [7:0] b, input logic [15:0] crc);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ (t << 4);
        return (crc >> 8) ^ {t, 8'h00} ^ {5'd0, t, 3'd0} ^ {12'd0, t[7:4]};
    endfunction

    // Per-message CRC extra; zero for ids outside the table
    function automatic logic [7:0] msg_crc_extra(input logic [15:0] id);
        case (id)
            16'd0:   return 8'd50;
            16'd1:   return 8'd124;
            16'd20:  return 8'd214;
            16'd21:  return 8'd159;
            16'd22:  return 8'd220;
            16'd24:  return 8'd24;
            16'd30:  return 8'd39;
            16'd33:  return 8'd104;
            16'd42:  return 8'd141;
            16'd44:  return 8'd221;
            16'd45:  return 8'd132;
            16'd47:  return 8'd221;
            16'd66:  return 8'd148;
            16'd74:  return 8'd20;
            16'd76:  return 8'd152;
            16'd147: return 8'd154;
            16'd253: return 8'd83;
            default: return 8'd0;
        endcase
    endfunction

    // Ground-station id list; consulted only for v2 ids that have no CRC extra
    function automatic logic passes_without_crc(input logic [15:0] id);
        return (id == 16'd20) || (id == 16'd21) || (id == 16'd45) ||
               (id == 16'd66) || (id == 16'd76);
    endfunction

endpackage

module mfr_frame_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            byte_valid,
    input  logic                            byte_ready,
    input  logic [7:0]                      byte_data,
    input  logic                            res_valid,
    input  logic                            res_ready,
    input  logic                            res_accepted,
    input  logic                            res_v2,
    input  logic [15:0]                     res_id,
    input  logic [7:0]                      res_len,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    output int                              mismatches,
    output int                              frames_outstanding
);
    import mfr_pkg::*;
    import mfr_tb_ref::*;

    // Predictor copy of the registers and the framing state
    logic [7:0]    v2_start;
    logic [7:0]    v1_start;
    int unsigned   pos;
    logic          framing_v2;
    logic [7:0]    hdr_len;
    logic [15:0]   hdr_id;
    logic [15:0]   crc_acc;
    logic [7:0]    ck_lo;
    logic          skip_next;

    frame_result_t expected_frames[$];
    int            fail_count;

    // Advance the framing state by one received byte; queue a result at frame end
    task automatic take_byte(input logic [7:0] b);
        int unsigned   p;
        int unsigned   total;
        logic [7:0]    extra;
        frame_result_t r;
        p = pos;
        if (p >= BUFFER_BYTES)
            p = 0;
        if (p == 0)
        begin
            crc_acc    = CRC_SEED;
            hdr_id     = '0;
            ck_lo      = '0;
            framing_v2 = (b == v2_start);
            skip_next  = (b != v2_start) && (b != v1_start);
            pos        = 1;
        end
        else if (skip_next)
        begin
            // Drop the byte after a bad start byte
            skip_next = 1'b0;
            pos       = 0;
        end
        else if (p == 1)
        begin
            hdr_len = b;
            crc_acc = mcrf4xx_update(b, crc_acc);
            pos     = 2;
        end
        else
        begin
            total = (framing_v2 ? 12 : 8) + hdr_len;
            if (framing_v2 && p == 7)
                hdr_id[7:0] = b;
            if (framing_v2 && p == 8)
                hdr_id[15:8] = b;
            if (!framing_v2 && p == 5)
                hdr_id = {8'h00, b};
            if (p <= total - 3)
            begin
                crc_acc = mcrf4xx_update(b, crc_acc);
                pos     = p + 1;
            end
            else if (p == total - 2)
            begin
                ck_lo = b;
                pos   = p + 1;
            end
            else
            begin
                // Last byte: fold in the extra and test the checksum
                extra = msg_crc_extra(hdr_id);
                if (framing_v2 && extra == 8'd0)
                    r.accepted = passes_without_crc(hdr_id);
                else
                    r.accepted = (mcrf4xx_update(extra, crc_acc) == {b, ck_lo});
                r.v2  = framing_v2;
                r.id  = hdr_id;
                r.len = hdr_len;
                expected_frames.push_back(r);
                pos = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        frame_result_t want;
        frame_result_t seen;
        if (!rst_n)
        begin
            v2_start   = START_V2_AT_RESET;
            v1_start   = START_V1_AT_RESET;
            pos        = 0;
            framing_v2 = 1'b0;
            hdr_len    = '0;
            hdr_id     = '0;
            crc_acc    = CRC_SEED;
            ck_lo      = '0;
            skip_next  = 1'b0;
            expected_frames.delete();
            fail_count = 0;
            mismatches         <= 0;
            frames_outstanding <= 0;
        end
        else
        begin
            // Compare each result transfer with the oldest expectation
            if (res_valid && res_ready)
            begin
                seen.accepted = res_accepted;
                seen.v2       = res_v2;
                seen.id       = res_id;
                seen.len      = res_len;
                if (expected_frames.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result with nothing expected: acc=%0b v2=%0b id=%0d len=%0d",
                                 $realtime, seen.accepted, seen.v2, seen.id, seen.len);
                    fail_count++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (seen.accepted !== want.accepted || seen.v2 !== want.v2 ||
                        seen.id !== want.id || seen.len !== want.len)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: result mismatch: want acc=%0b v2=%0b id=%0d len=%0d",
                                     $realtime, want.accepted, want.v2, want.id, want.len);
                            $display("    got acc=%0b v2=%0b id=%0d len=%0d",
                                     seen.accepted, seen.v2, seen.id, seen.len);
                        end
                        fail_count++;
                    end
                end
            end

            // Predict from each byte transfer
            if (byte_valid && byte_ready)
                take_byte(byte_data);

            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_V2_MAGIC)
                    v2_start = cfg_data;
                else if (cfg_index == CFG_V1_MAGIC)
                    v1_start = cfg_data;
            end

            mismatches         <= fail_count;
            frames_outstanding <= expected_frames.size();
        end
    end

endmodule

@@ dv/mavlink_frame_receiver_tb.sv @@
// Top of the MAVLink frame receiver bench: clock, reset, byte and register stimulus, verdict.
`timescale 1ns / 1ps

module mavlink_frame_receiver_tb;
    import mfr_pkg::*;
    import mfr_tb_ref::*;

    localparam int RESET_CYCLES      = 12;
    localparam int RANDOM_BYTES      = 700;
    localparam int SETTLE_CYCLES     = 6;
    localparam int LONG_HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT       = 400000;

    typedef enum {PACE_OPEN, PACE_COIN, PACE_MOSTLY, PACE_SPARSE} pace_t;

    logic clk;
    logic rst_n;

    mfr_byte_if   byte_ch ();
    mfr_result_if result_ch ();
    mfr_cfg_if    cfg_ch ();

    int mismatches;
    int frames_outstanding;

    bit         hold_request;
    bit         hold_served;
    int         burst_left;
    int         bytes_sent;
    logic [7:0] v2_now;
    logic [7:0] v1_now;
    logic [7:0] frame_q[$];

    logic [15:0] table_ids[17] = '{16'd0, 16'd1, 16'd20, 16'd21, 16'd22, 16'd24, 16'd30,
                                   16'd33, 16'd42, 16'd44, 16'd45, 16'd47, 16'd66, 16'd74,
                                   16'd76, 16'd147, 16'd253};

    mavlink_frame_receiver dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .result_out (result_ch),
        .cfg        (cfg_ch)
    );

    mfr_frame_checker frame_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .byte_valid         (byte_ch.valid),
        .byte_ready         (byte_ch.ready),
        .byte_data          (byte_ch.rx_byte),
        .res_valid          (result_ch.valid),
        .res_ready          (result_ch.ready),
        .res_accepted       (result_ch.frame_accepted),
        .res_v2             (result_ch.is_version_two),
        .res_id             (result_ch.message_id),
        .res_len            (result_ch.payload_length),
        .cfg_valid          (cfg_ch.valid),
        .cfg_ready          (cfg_ch.ready),
        .cfg_index          (cfg_ch.index),
        .cfg_data           (cfg_ch.data),
        .mismatches         (mismatches),
        .frames_outstanding (frames_outstanding)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("mavlink_frame_receiver_tb NOT OK");
        $finish;
    end

    // Pace the result side; serve one long hold-off on request
    initial
    begin : result_pacing
        int    run_left;
        pace_t pace;
        run_left    = 0;
        pace        = PACE_OPEN;
        hold_served = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_served)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_served = 1'b1;
            end
            if (run_left == 0)
            begin
                pace     = pace_t'($urandom_range(0, 3));
                run_left = $urandom_range(4, 64);
            end
            run_left--;
            case (pace)
                PACE_OPEN:   result_ch.ready <= 1'b1;
                PACE_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                PACE_MOSTLY: result_ch.ready <= ($urandom_range(0, 3) != 0);
                default:     result_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Offer one byte, with a random gap at the start of each burst; return on its transfer
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do @(posedge clk); while (!byte_ch.ready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_queue();
        while (frame_q.size() != 0)
            send_byte(frame_q.pop_front());
    endtask

    // Drop valid and wait until every expected frame is in, plus the pipeline tail
    task automatic settle();
        byte_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (frames_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both start bytes back to back while idle
    task automatic set_magics(input logic [7:0] v2_val, input logic [7:0] v1_val);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_V2_MAGIC;
        cfg_ch.data  <= v2_val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= CFG_V1_MAGIC;
        cfg_ch.data  <= v1_val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        v2_now = v2_val;
        v1_now = v1_val;
    endtask

    // Append one frame with random header fields and payload; optionally break its checksum
    function automatic void build_frame(input bit v2, input logic [7:0] len,
                                        input logic [23:0] msg_id, input bit corrupt);
        logic [7:0]  body[$];
        logic [15:0] crc;
        logic [15:0] id16;
        body.push_back(len);
        if (v2)
        begin
            repeat (5) body.push_back(8'($urandom));
            body.push_back(msg_id[7:0]);
            body.push_back(msg_id[15:8]);
            body.push_back(msg_id[23:16]);
        end
        else
        begin
            repeat (3) body.push_back(8'($urandom));
            body.push_back(msg_id[7:0]);
        end
        repeat (len) body.push_back(8'($urandom));
        crc = CRC_SEED;
        foreach (body[i])
            crc = mcrf4xx_update(body[i], crc);
        id16 = v2 ? msg_id[15:0] : {8'h00, msg_id[7:0]};
        crc  = mcrf4xx_update(msg_crc_extra(id16), crc);
        if (corrupt)
            crc ^= 16'(1) << $urandom_range(0, 15);
        frame_q.push_back(v2 ? v2_now : v1_now);
        foreach (body[i])
            frame_q.push_back(body[i]);
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
    endfunction

    // Mostly good frames with random content; some broken, unknown, noisy or cut short
    task automatic queue_random_traffic();
        int          kind;
        bit          v2;
        logic [7:0]  len;
        logic [23:0] known;
        kind  = $urandom_range(0, 99);
        v2    = 1'($urandom_range(0, 1));
        len   = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(17, 255))
                                             : 8'($urandom_range(0, 16));
        known = {8'($urandom), table_ids[$urandom_range(0, 16)]};
        if (kind < 70)
            build_frame(v2, len, known, 1'b0);
        else if (kind < 80)
            build_frame(v2, len, known, 1'b1);
        else if (kind < 86)
            build_frame(v2, len, 24'($urandom), 1'b0);
        else if (kind < 94)
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
        else
        begin
            build_frame(v2, len, known, 1'b0);
            repeat ($urandom_range(1, 4)) void'(frame_q.pop_back());
        end
        send_queue();
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        int phase_start;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = 8'h00;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_V2_MAGIC;
        cfg_ch.data     = 8'h00;
        hold_request    = 1'b0;
        burst_left      = 0;
        bytes_sent      = 0;
        v2_now          = START_V2_AT_RESET;
        v1_now          = START_V1_AT_RESET;
        rst_n           = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset start bytes
        build_frame(1'b0, 8'd0, 24'd0, 1'b0);
        build_frame(1'b1, 8'd0, 24'd1, 1'b0);
        build_frame(1'b1, 8'd255, 24'hFF00FD, 1'b0);
        build_frame(1'b0, 8'd3, 24'd24, 1'b1);
        build_frame(1'b1, 8'd2, 24'h00FFFF, 1'b0);
        build_frame(1'b0, 8'd1, 24'h0000FF, 1'b0);
        build_frame(1'b1, 8'd4, 24'd20, 1'b0);
        build_frame(1'b1, 8'd1, 24'h01002A, 1'b0);
        // Bad start byte: it and the following start byte are both dropped
        frame_q.push_back(8'h00);
        frame_q.push_back(v2_now);
        build_frame(1'b0, 8'd5, 24'd76, 1'b0);
        send_queue();

        // Change the v2 start byte in the middle of a v2 frame
        build_frame(1'b1, 8'd6, 24'd33, 1'b0);
        repeat (5) send_byte(frame_q.pop_front());
        set_magics(8'h11, v1_now);
        send_queue();

        // Equal start bytes at zero: v2 wins
        set_magics(8'h00, 8'h00);
        build_frame(1'b1, 8'd3, 24'd0, 1'b0);
        build_frame(1'b0, 8'd3, 24'd1, 1'b0);
        send_queue();

        // Extreme start bytes both ways
        set_magics(8'hFF, 8'h00);
        build_frame(1'b1, 8'd2, 24'd42, 1'b0);
        build_frame(1'b0, 8'd2, 24'd44, 1'b0);
        send_queue();
        set_magics(8'h00, 8'hFF);
        build_frame(1'b1, 8'd2, 24'd147, 1'b0);
        build_frame(1'b0, 8'd2, 24'd22, 1'b0);
        send_queue();

        // Random traffic over several register settings
        settle();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_magics(START_V2_AT_RESET, START_V1_AT_RESET);
                1:
                begin
                    set_magics(8'($urandom), 8'($urandom));
                    hold_request = 1'b1;
                end
                2:
                begin
                    v2_now = 8'($urandom);
                    set_magics(v2_now, v2_now);
                end
                default: set_magics(8'hFF, 8'h00);
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < RANDOM_BYTES / 4)
                queue_random_traffic();
        end

        settle();
        if (mismatches == 0)
            $display("mavlink_frame_receiver_tb OK");
        else
            $display("mavlink_frame_receiver_tb NOT OK");
        $finish;
    end

endmodule
